// ----- rtl/core/vca_pkg.sv -----
`timescale 1ns / 1ps

package vca_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 31;
  localparam int TAG_W      = 7;
  localparam int CHAN_W     = 5;

  localparam int DEF_FIRST_CHANNEL = 2;
  localparam int DEF_LAST_CHANNEL  = 16;

  typedef enum logic [1:0] {
    ST_ASSIGNED   = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NO_CHANNEL = 2'd2
  } status_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_COUNT-1:0] grant;
    logic [SLOT_COUNT-1:0] expire;
  } pick_t;

  // Channel numbers live in 1..16.
  function automatic int clamp_channel(int c);
    int r;
    r = c;
    if (c < 1) r = 1;
    if (c > SLOT_COUNT) r = SLOT_COUNT;
    return r;
  endfunction

endpackage

// ----- rtl/core/vca_pick.sv -----
`timescale 1ns / 1ps

module vca_pick #(
  parameter int FIRST_CHANNEL = vca_pkg::DEF_FIRST_CHANNEL,
  parameter int LAST_CHANNEL  = vca_pkg::DEF_LAST_CHANNEL
) (
  input  logic [vca_pkg::SLOT_COUNT-1:0] busy,
  input  logic [vca_pkg::TIME_W-1:0]     release_time [vca_pkg::SLOT_COUNT],
  input  logic [vca_pkg::TIME_W-1:0]     start,
  output vca_pkg::pick_t                 pick
);
  import vca_pkg::*;

  localparam int LO_SLOT = clamp_channel(FIRST_CHANNEL) - 1;
  localparam int HI_SLOT = clamp_channel(LAST_CHANNEL) - 1;

  logic [SLOT_COUNT-1:0] pool;
  logic [SLOT_COUNT-1:0] expire;
  logic [SLOT_COUNT-1:0] free;
  logic [SLOT_COUNT-1:0] grant;
  logic [SLOT_W-1:0]     slot;

  // Free a slot in the pool that is idle or whose note has ended by start.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool[i]   = (i >= LO_SLOT) && (i <= HI_SLOT);
      expire[i] = pool[i] && busy[i] && (release_time[i] <= start);
      free[i]   = pool[i] && (!busy[i] || expire[i]);
    end
  end

  // Lowest free slot wins.
  assign grant = free & (~free + {{(SLOT_COUNT-1){1'b0}}, 1'b1});

  always_comb begin
    slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (grant[i]) begin
        slot = slot | i[SLOT_W-1:0];
      end
    end
  end

  assign pick.found  = |free;
  assign pick.slot   = slot;
  assign pick.grant  = grant;
  assign pick.expire = expire;

endmodule

// ----- rtl/core/voice_channel_allocator_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake              | Fields
// input    | in_valid / in_ready    | note_start, note_stop, note_key
// result   | out_valid / out_ready  | status, channel, note_tag
//
// One item per cycle while out_ready is high; input register, then result register.
// The scan of all slot release times and the lowest-free encoder are combinational
// between those registers; the slot state updates when the result register loads.
// Reset (rst, synchronous) clears both valid flags and all busy flags.
// A stalled result holds; the input register refills as soon as its item moves on.

module voice_channel_allocator_unit #(
  parameter int FIRST_CHANNEL = vca_pkg::DEF_FIRST_CHANNEL,
  parameter int LAST_CHANNEL  = vca_pkg::DEF_LAST_CHANNEL
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [vca_pkg::TIME_W-1:0] note_start,
  input  logic [vca_pkg::TIME_W-1:0] note_stop,
  input  logic [vca_pkg::TAG_W-1:0]  note_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [vca_pkg::CHAN_W-1:0] channel,
  output logic [vca_pkg::TAG_W-1:0]  note_tag
);
  import vca_pkg::*;

  // Input register
  logic              hold_vld;
  logic [TIME_W-1:0] hold_start;
  logic [TIME_W-1:0] hold_stop;
  logic [TAG_W-1:0]  hold_tag;

  // Slot state
  logic [SLOT_COUNT-1:0] busy;
  logic [SLOT_COUNT-1:0] busy_next;
  logic [TIME_W-1:0]     release_time [SLOT_COUNT];

  // Result register
  logic              res_vld;
  status_t           res_status;
  logic [CHAN_W-1:0] res_channel;
  logic [TAG_W-1:0]  res_tag;

  logic    take;
  logic    advance;
  logic    empty_dur;
  logic    assign_ok;
  pick_t   pick;
  status_t status_next;

  // Advance the held item whenever the result register is empty or draining.
  assign advance  = hold_vld && (!res_vld || out_ready);
  assign in_ready = !hold_vld || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (take) begin
      hold_vld <= 1'b1;
    end else if (advance) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_start <= note_start;
      hold_stop  <= note_stop;
      hold_tag   <= note_key;
    end
  end

  vca_pick #(
    .FIRST_CHANNEL(FIRST_CHANNEL),
    .LAST_CHANNEL (LAST_CHANNEL)
  ) u_pick (
    .busy        (busy),
    .release_time(release_time),
    .start       (hold_start),
    .pick        (pick)
  );

  // Drop a note with no duration before touching any slot.
  assign empty_dur = (hold_stop <= hold_start);
  assign assign_ok = !empty_dur && pick.found;

  always_comb begin
    busy_next = busy;
    if (!empty_dur) begin
      busy_next = (busy & ~pick.expire) | pick.grant;
    end
  end

  always_comb begin
    priority if (empty_dur) begin
      status_next = ST_EMPTY;
    end else if (pick.found) begin
      status_next = ST_ASSIGNED;
    end else begin
      status_next = ST_NO_CHANNEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (advance) begin
      busy <= busy_next;
    end
  end

  // Record the stop time of the granted slot.
  always_ff @(posedge clk) begin
    if (advance && assign_ok) begin
      release_time[pick.slot] <= hold_stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (out_ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status  <= status_next;
      res_channel <= assign_ok ? ({1'b0, pick.slot} + CHAN_W'(1)) : '0;
      res_tag     <= hold_tag;
    end
  end

  assign out_valid = res_vld;
  assign status    = res_status;
  assign channel   = res_channel;
  assign note_tag  = res_tag;

endmodule

// ----- rtl/core/vca_checker.sv -----
`timescale 1ns / 1ps

module vca_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 status,
  input logic [vca_pkg::CHAN_W-1:0] channel
);
  import vca_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_ASSIGNED || status == ST_EMPTY ||
                   status == ST_NO_CHANNEL))
    else $error("result status code out of range");

  a_drop_channel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ASSIGNED) |-> (channel == '0))
    else $error("dropped item carries a channel");

  a_assign_channel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ASSIGNED) |->
      (channel != '0 && channel <= CHAN_W'(SLOT_COUNT)))
    else $error("assigned channel out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(channel) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind voice_channel_allocator_unit vca_checker u_vca_checker (.*);

// ----- dv/voice_alloc_checker.sv -----
`timescale 1ns / 1ps

module voice_alloc_checker #(
  parameter int FIRST_CHANNEL = vca_pkg::DEF_FIRST_CHANNEL,
  parameter int LAST_CHANNEL  = vca_pkg::DEF_LAST_CHANNEL
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [vca_pkg::TIME_W-1:0] note_start,
  input  logic [vca_pkg::TIME_W-1:0] note_stop,
  input  logic [vca_pkg::TAG_W-1:0]  note_key,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 status,
  input  logic [vca_pkg::CHAN_W-1:0] channel,
  input  logic [vca_pkg::TAG_W-1:0]  note_tag,
  output int                         mismatch_count,
  output int                         owed_count
);
  import vca_pkg::*;

  // Pool bounds, limited to the legal channel numbers.
  localparam int POOL_LO = (FIRST_CHANNEL < 1) ? 1 :
                           (FIRST_CHANNEL > SLOT_COUNT) ? SLOT_COUNT : FIRST_CHANNEL;
  localparam int POOL_HI = (LAST_CHANNEL < 1) ? 1 :
                           (LAST_CHANNEL > SLOT_COUNT) ? SLOT_COUNT : LAST_CHANNEL;

  typedef struct packed {
    status_t           st;
    logic [CHAN_W-1:0] chan;
    logic [TAG_W-1:0]  tag;
  } grant_t;

  logic              slot_busy    [SLOT_COUNT];
  logic [TIME_W-1:0] slot_release [SLOT_COUNT];
  grant_t            owed_grants  [$];
  int                bad_fields;

  // Free expired slots, then take the lowest free one in the pool.
  function automatic grant_t allocate_note(input logic [TIME_W-1:0] t_on,
                                           input logic [TIME_W-1:0] t_off,
                                           input logic [TAG_W-1:0]  num);
    grant_t g;
    g.st   = ST_NO_CHANNEL;
    g.chan = '0;
    g.tag  = num;
    if (t_off <= t_on) begin
      g.st = ST_EMPTY;
    end else begin
      for (int ch = POOL_LO; ch <= POOL_HI; ch++) begin
        if (slot_busy[ch-1] && slot_release[ch-1] <= t_on) slot_busy[ch-1] = 1'b0;
      end
      for (int ch = POOL_LO; ch <= POOL_HI; ch++) begin
        if (!slot_busy[ch-1]) begin
          slot_busy[ch-1]    = 1'b1;
          slot_release[ch-1] = t_off;
          g.st   = ST_ASSIGNED;
          g.chan = CHAN_W'(ch);
          break;
        end
      end
    end
    return g;
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_busy[i]    = 1'b0;
        slot_release[i] = '0;
      end
      owed_grants.delete();
      bad_fields = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_grants.size() == 0) begin
          $display("%0t: result with none expected, status %0d channel %0d tag %0d",
                   $time, status, channel, note_tag);
          bad_fields++;
        end else begin
          g = owed_grants.pop_front();
          check_field("status", g.st, status);
          check_field("channel", g.chan, channel);
          check_field("note_tag", g.tag, note_tag);
        end
      end
      if (in_valid && in_ready)
        owed_grants.insert(owed_grants.size(),
                           allocate_note(note_start, note_stop, note_key));
    end
    mismatch_count <= bad_fields;
    owed_count     <= owed_grants.size();
  end

endmodule

// ----- dv/voice_channel_allocator_unit_tb.sv -----
`timescale 1ns / 1ps

module voice_channel_allocator_unit_tb;
  import vca_pkg::*;

  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  localparam int NOTE_TARGET = 1550;
  // Sized for roughly 1600 items, each slowed by sender gaps and receiver stalls,
  // with a margin several times over.
  localparam int CYCLE_LIMIT = 400000;
  // Keep the time cursor clear of the top so note stops never wrap.
  localparam logic [31:0] CURSOR_CEIL = 32'h7FF0_0000;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TIME_W-1:0] note_start = '0;
  logic [TIME_W-1:0] note_stop = '0;
  logic [TAG_W-1:0]  note_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [CHAN_W-1:0] channel;
  logic [TAG_W-1:0]  note_tag;

  int mismatch_count;
  int owed_count;
  int cycle_count = 0;

  voice_channel_allocator_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .note_start  (note_start),
    .note_stop   (note_stop),
    .note_key    (note_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .channel     (channel),
    .note_tag    (note_tag)
  );

  voice_alloc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .note_start     (note_start),
    .note_stop      (note_stop),
    .note_key       (note_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .channel        (channel),
    .note_tag       (note_tag),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver back-pressure. Switch at random between always ready, coin-flip stalls
  // and heavy stalls so stalls land on every pipeline phase.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Present one note and hold it until the block takes it. Valid stays high
  // on return so back-to-back items need no second assignment in one step.
  task automatic send_note(input logic [TIME_W-1:0] t_on, input logic [TIME_W-1:0] t_off,
                           input logic [TAG_W-1:0] num);
    in_valid   <= 1'b1;
    note_start <= t_on;
    note_stop  <= t_off;
    note_key   <= num;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [31:0] cursor;
    logic [31:0] t_on;
    logic [31:0] t_off;
    int          sent;
    int          burst;
    int          seg_left;
    int          step_max;
    int          dur_max;
    int          pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty durations at the field extremes.
    send_note('0, '0, '0);
    send_note(T_MAX, '0, 7'd127);
    send_note(31'd100, 31'd50, 7'd5);
    send_note(T_MAX, T_MAX, 7'd1);
    // Fill the whole pool; release times 20..34 on channels 2..16.
    for (int i = 0; i < 15; i++) send_note(31'd10, 31'(20 + i), 7'(10 + i));
    // Pool full: longest possible note is dropped.
    send_note(31'd10, T_MAX, 7'd127);
    // Start one short of the earliest release: nothing frees.
    send_note(31'd19, 31'd25, 7'd3);
    // Start equal to a release time frees that channel.
    send_note(31'd20, 31'd40, 7'd4);
    // Out-of-order start earlier than everything: still full.
    send_note(31'd5, 31'd6, 7'd6);
    // Frees everything released by 34; lowest free channel wins.
    send_note(31'd34, 31'd50, 7'd7);

    // Random: mostly sorted note streams with random density, plus noise.
    cursor   = 32'd1000;
    sent     = 0;
    seg_left = 0;
    step_max = 1;
    dur_max  = 8;
    while (sent < NOTE_TARGET) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        // New density segment: tight overlaps fill the pool, sparse ones drain it.
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: begin step_max = 0;  dur_max = 8;    end
            1: begin step_max = 2;  dur_max = 40;   end
            2: begin step_max = 8;  dur_max = 256;  end
            default: begin step_max = 64; dur_max = 4096; end
          endcase
        end
        seg_left--;
        // Occasional forward jump walks the start times up through the high bits.
        if ($urandom_range(0, 31) == 0 && cursor < CURSOR_CEIL - 32'h0400_0000)
          cursor = cursor + $urandom_range(0, 32'h0400_0000);
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          cursor = cursor + $urandom_range(0, step_max);
          t_on   = cursor;
          t_off  = cursor + $urandom_range(1, dur_max);
        end else if (pick < 95) begin
          // Noise: any values with an empty duration; state must not move.
          t_on  = $urandom & 32'h7FFF_FFFF;
          t_off = $urandom_range(0, 1) ? t_on : (t_on & $urandom);
        end else begin
          // Out-of-order arrival behind the cursor, short enough to drain soon.
          t_on  = $urandom_range(0, cursor);
          t_off = t_on + $urandom_range(0, 64);
        end
        send_note(t_on[TIME_W-1:0], t_off[TIME_W-1:0], 7'($urandom));
        sent++;
      end
      // Idle gap between bursts; sometimes none at all.
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then wait on for strays.
    while (owed_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/vca_pkg.sv
rtl/core/vca_pick.sv
rtl/core/voice_channel_allocator_unit.sv
rtl/core/vca_checker.sv
dv/voice_alloc_checker.sv
dv/voice_channel_allocator_unit_tb.sv
